// ===== rtl/thmcr_pkg.sv =====
// Shared types, constants and helper functions for the two-hop route selector.
// Used by thmcr_link_mem, thmcr_seq and the top level; depends on nothing else.
package thmcr_pkg;

    localparam int MAX_LINKS = 64;
    localparam int NODE_BITS = 8;
    localparam int COST_BITS = 16;

    localparam int IDX_BITS  = $clog2(MAX_LINKS);
    localparam int CNT_BITS  = $clog2(MAX_LINKS + 1);
    localparam int SUM_BITS  = COST_BITS + 1;
    // the no-direct bound must fit whatever the cost width is
    localparam int BEST_BITS = (SUM_BITS > 14) ? SUM_BITS : 14;

    localparam logic [BEST_BITS-1:0] NO_DIRECT_BOUND = BEST_BITS'(9999);
    localparam logic [CNT_BITS-1:0]  LINK_LIMIT      = CNT_BITS'(MAX_LINKS);

    localparam logic [1:0] HOPS_NONE   = 2'd0;
    localparam logic [1:0] HOPS_DIRECT = 2'd1;
    localparam logic [1:0] HOPS_TWO    = 2'd2;

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_ROUTE = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIR,
        S_OREQ,
        S_OCHK,
        S_INNER,
        S_RES,
        S_FIN
    } t_state;

    typedef struct packed {
        t_op                  operation;
        logic [NODE_BITS-1:0] node_a;
        logic [NODE_BITS-1:0] node_b;
        logic [COST_BITS-1:0] distance;
        logic [COST_BITS-1:0] price;
    } t_in_item;

    typedef struct packed {
        t_status             status;
        logic [1:0]          hops;
        logic [IDX_BITS-1:0] first_link;
        logic [IDX_BITS-1:0] second_link;
        logic [SUM_BITS-1:0] route_cost;
    } t_out_item;

    typedef struct packed {
        logic [NODE_BITS-1:0] end_a;
        logic [NODE_BITS-1:0] end_b;
        logic [COST_BITS-1:0] distance;
        logic [COST_BITS-1:0] price;
    } t_link;

    typedef struct packed {
        logic                we;
        logic [IDX_BITS-1:0] waddr;
        t_link               wdata;
        logic                re;
        logic [IDX_BITS-1:0] raddr;
    } t_mem_req;

    function automatic logic touches(input t_link l, input logic [NODE_BITS-1:0] n);
        return (l.end_a == n) || (l.end_b == n);
    endfunction

    function automatic logic [COST_BITS-1:0] cost_of(input t_link l, input logic crit);
        return crit ? l.distance : l.price;
    endfunction

endpackage

// ===== rtl/two_hop_min_cost_route_select.sv =====
// Top level of the two-hop route selector: criterion register, output register
// and the link table with its sequencer. Depends on thmcr_pkg, thmcr_link_mem, thmcr_seq.
//
// One item is handled at a time; the next is taken while a finished result waits
// in the output register. An add-link item or a query with equal nodes goes
// straight to the result. Any other query runs through the one memory read port:
// a direct-link scan, then a first-hop pass over the stored links, with a full
// second-hop scan for every first hop that leaves the source towards a third
// node, and then the result is built.
module two_hop_min_cost_route_select
    import thmcr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic      r_crit;
    logic      r_out_valid;
    t_out_item r_out_item;

    t_mem_req  w_mem_req;
    t_link     w_rd_data;
    logic      w_res_valid;
    logic      w_res_take;
    t_out_item w_res;

    // hand a result over whenever the output register is empty or being drained
    assign w_res_take = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crit      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_crit <= i_cfg_wdata;
            end
            if (w_res_valid && w_res_take) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_take) begin
            r_out_item <= w_res;
        end
    end

    thmcr_link_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (w_mem_req),
        .o_rd_data (w_rd_data)
    );

    thmcr_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_crit      (r_crit),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_mem_req   (w_mem_req),
        .i_rd_data   (w_rd_data),
        .o_res_valid (w_res_valid),
        .i_res_take  (w_res_take),
        .o_res       (w_res)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== rtl/thmcr_link_mem.sv =====
// Link table: one write port and one registered read port.
// Depends on thmcr_pkg for the link record and request types.
module thmcr_link_mem
    import thmcr_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_link    o_rd_data
);

    t_link r_mem [MAX_LINKS];
    t_link r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/thmcr_seq.sv =====
// Sequencer for link appends and route queries: scans the link table through
// the memory read port and keeps the best route. Depends on thmcr_pkg.
module thmcr_seq
    import thmcr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_crit,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output t_mem_req  o_mem_req,
    input  t_link     i_rd_data,
    output logic      o_res_valid,
    input  logic      i_res_take,
    output t_out_item o_res
);

    t_state               r_state, n_state;
    logic [CNT_BITS-1:0]  r_cnt, n_cnt;
    logic [NODE_BITS-1:0] r_src, n_src;
    logic [NODE_BITS-1:0] r_dst, n_dst;
    logic [CNT_BITS-1:0]  r_idx, n_idx;
    logic                 r_pend, n_pend;
    logic [IDX_BITS-1:0]  r_pidx, n_pidx;
    logic [CNT_BITS-1:0]  r_oi, n_oi;
    logic                 r_have, n_have;
    logic [IDX_BITS-1:0]  r_direct, n_direct;
    logic [IDX_BITS-1:0]  r_first, n_first;
    logic [IDX_BITS-1:0]  r_second, n_second;
    logic [1:0]           r_hops, n_hops;
    logic [BEST_BITS-1:0] r_best, n_best;
    logic [NODE_BITS-1:0] r_mid, n_mid;
    logic [COST_BITS-1:0] r_ocost, n_ocost;
    t_out_item            r_res, n_res;

    logic                 w_accept;
    logic                 w_issue;
    logic [COST_BITS-1:0] w_rd_cost;
    logic [NODE_BITS-1:0] w_rd_mid;
    logic [BEST_BITS-1:0] w_sum;
    logic                 w_qualify;

    assign w_accept  = i_in_valid && o_in_ready;
    assign w_issue   = (r_idx < r_cnt);
    assign w_rd_cost = cost_of(i_rd_data, i_crit);
    assign w_rd_mid  = (i_rd_data.end_a != r_src) ? i_rd_data.end_a : i_rd_data.end_b;
    assign w_sum     = BEST_BITS'(r_ocost) + BEST_BITS'(w_rd_cost);
    assign w_qualify = !(r_have && (r_oi[IDX_BITS-1:0] == r_direct))
                       && touches(i_rd_data, r_src)
                       && (w_rd_mid != r_src) && (w_rd_mid != r_dst);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src    <= n_src;
        r_dst    <= n_dst;
        r_idx    <= n_idx;
        r_pidx   <= n_pidx;
        r_oi     <= n_oi;
        r_have   <= n_have;
        r_direct <= n_direct;
        r_first  <= n_first;
        r_second <= n_second;
        r_hops   <= n_hops;
        r_best   <= n_best;
        r_mid    <= n_mid;
        r_ocost  <= n_ocost;
        r_res    <= n_res;
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_src    = r_src;
        n_dst    = r_dst;
        n_idx    = r_idx;
        n_pend   = r_pend;
        n_pidx   = r_pidx;
        n_oi     = r_oi;
        n_have   = r_have;
        n_direct = r_direct;
        n_first  = r_first;
        n_second = r_second;
        n_hops   = r_hops;
        n_best   = r_best;
        n_mid    = r_mid;
        n_ocost  = r_ocost;
        n_res    = r_res;

        o_mem_req.we          = 1'b0;
        o_mem_req.waddr       = r_cnt[IDX_BITS-1:0];
        o_mem_req.wdata.end_a = i_in_item.node_a;
        o_mem_req.wdata.end_b = i_in_item.node_b;
        o_mem_req.wdata.distance = i_in_item.distance;
        o_mem_req.wdata.price = i_in_item.price;
        o_mem_req.re          = 1'b0;
        o_mem_req.raddr       = r_idx[IDX_BITS-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_src = i_in_item.node_a;
                    n_dst = i_in_item.node_b;
                    n_res = '{status: ST_OK, hops: HOPS_NONE, first_link: '0,
                              second_link: '0, route_cost: '0};
                    if (i_in_item.operation == OP_ADD) begin
                        n_state = S_FIN;
                        if (r_cnt >= LINK_LIMIT) begin
                            n_res.status = ST_FULL;
                        end else begin
                            o_mem_req.we     = 1'b1;
                            n_cnt            = r_cnt + 1'b1;
                            n_res.first_link = r_cnt[IDX_BITS-1:0];
                        end
                    end else if (i_in_item.node_a == i_in_item.node_b) begin
                        n_state = S_FIN;
                    end else begin
                        n_have   = 1'b0;
                        n_direct = '0;
                        n_first  = '0;
                        n_second = '0;
                        n_hops   = HOPS_NONE;
                        n_best   = NO_DIRECT_BOUND;
                        n_idx    = '0;
                        n_pend   = 1'b0;
                        n_oi     = '0;
                        n_state  = S_DIR;
                    end
                end
            end

            // pipelined scan for the first direct link
            S_DIR: begin
                o_mem_req.re = w_issue;
                n_pend       = w_issue;
                n_pidx       = r_idx[IDX_BITS-1:0];
                if (w_issue) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_pend && touches(i_rd_data, r_src) && touches(i_rd_data, r_dst)) begin
                    n_have   = 1'b1;
                    n_direct = r_pidx;
                    n_first  = r_pidx;
                    n_hops   = HOPS_DIRECT;
                    n_best   = BEST_BITS'(w_rd_cost);
                    n_pend   = 1'b0;
                    n_state  = S_OREQ;
                end else if (!r_pend && !w_issue) begin
                    n_state = S_OREQ;
                end
            end

            S_OREQ: begin
                o_mem_req.raddr = r_oi[IDX_BITS-1:0];
                if (r_oi < r_cnt) begin
                    o_mem_req.re = 1'b1;
                    n_state      = S_OCHK;
                end else begin
                    n_state = S_RES;
                end
            end

            S_OCHK: begin
                if (w_qualify) begin
                    n_mid   = w_rd_mid;
                    n_ocost = w_rd_cost;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_state = S_INNER;
                end else begin
                    n_oi    = r_oi + 1'b1;
                    n_state = S_OREQ;
                end
            end

            // pipelined scan for second hops from the held middle node
            S_INNER: begin
                o_mem_req.re = w_issue;
                n_pend       = w_issue;
                n_pidx       = r_idx[IDX_BITS-1:0];
                if (w_issue) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_pend && touches(i_rd_data, r_mid) && touches(i_rd_data, r_dst)
                        && (w_sum < r_best)) begin
                    n_best   = w_sum;
                    n_first  = r_oi[IDX_BITS-1:0];
                    n_second = r_pidx;
                    n_hops   = HOPS_TWO;
                    n_have   = 1'b1;
                end
                if (!r_pend && !w_issue) begin
                    n_oi    = r_oi + 1'b1;
                    n_state = S_OREQ;
                end
            end

            S_RES: begin
                n_state = S_FIN;
                if (!r_have) begin
                    n_res = '{status: ST_NO_ROUTE, hops: HOPS_NONE, first_link: '0,
                              second_link: '0, route_cost: '0};
                end else begin
                    n_res.status      = ST_OK;
                    n_res.hops        = r_hops;
                    n_res.first_link  = r_first;
                    n_res.second_link = (r_hops == HOPS_TWO) ? r_second : '0;
                    n_res.route_cost  = r_best[SUM_BITS-1:0];
                end
            end

            S_FIN: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_FIN);
    assign o_res       = r_res;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= LINK_LIMIT)
        else $error("link count beyond table size");

    a_write_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_req.we |-> (r_cnt < LINK_LIMIT) && (r_state == S_IDLE))
        else $error("link write while table full or busy");

    a_write_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_req.we |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("link count did not advance after write");

    a_read_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_req.re |-> (CNT_BITS'(o_mem_req.raddr) < r_cnt) && !o_mem_req.we)
        else $error("read of an unwritten link entry");

endmodule
